@@ rtl/vldm_pkg.sv @@
// ----------------------------------------------------------------------------
// vldm_pkg: shared types and constants for the value list block
// Sizes of the store, the count, the running sum and the request queue.
// ----------------------------------------------------------------------------
package vldm_pkg;

    // store size and derived widths
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 16;
    localparam int SUM_W     = VAL_W + IDX_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // request queue between front and back; depth a power of two so the
    // pointers wrap on their own
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] value;
    } t_req;

endpackage

@@ rtl/vldm_front.sv @@
// ----------------------------------------------------------------------------
// vldm_front: request intake
// Takes input beats into a two-entry queue so the list engine and the
// input side stall independently.
// ----------------------------------------------------------------------------
module vldm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  vldm_pkg::t_req      i_req,
    output logic                o_stall,
    output logic                o_q_valid,
    output vldm_pkg::t_req      o_q_req,
    input  logic                i_q_pop
);

    vldm_pkg::t_req                 r_buf [vldm_pkg::QDEPTH];
    logic [vldm_pkg::QPTR_W-1:0]    r_wp;
    logic [vldm_pkg::QPTR_W-1:0]    r_rp;
    logic [vldm_pkg::QCNT_W-1:0]    r_cnt;
    logic                           push;
    logic                           pop;

    assign o_stall   = (r_cnt == vldm_pkg::QCNT_W'(vldm_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_buf[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_req;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/vldm_div.sv @@
// ----------------------------------------------------------------------------
// vldm_div: unsigned restoring divider
// One quotient bit per cycle; the sum magnitude divided by the entry count.
// ----------------------------------------------------------------------------
module vldm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vldm_pkg::SUM_W-1:0]    i_dividend,
    input  logic [vldm_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [vldm_pkg::SUM_W-1:0]    o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [vldm_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [vldm_pkg::SUM_W-1:0]        r_q;
    logic [vldm_pkg::CNT_W:0]          r_rem;
    logic [vldm_pkg::CNT_W-1:0]        r_dvs;
    logic [vldm_pkg::CNT_W:0]          rem_sh;
    logic [vldm_pkg::CNT_W:0]          dvs_ext;
    logic                              ge;

    // one restoring step
    assign rem_sh  = {r_rem[vldm_pkg::CNT_W-1:0], r_q[vldm_pkg::SUM_W-1]};
    assign dvs_ext = {1'b0, r_dvs};
    assign ge      = (rem_sh >= dvs_ext);

    assign o_done     = r_done;
    assign o_quotient = r_q;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - dvs_ext) : rem_sh;
            r_q   <= {r_q[vldm_pkg::SUM_W-2:0], ge};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == vldm_pkg::DIV_CNT_W'(vldm_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

@@ rtl/vldm_list.sv @@
// ----------------------------------------------------------------------------
// vldm_list: list engine
// Holds the value store, runs append, search and gap-closing shift,
// keeps count and running sum, and drives the registered result beat.
// ----------------------------------------------------------------------------
module vldm_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  vldm_pkg::t_req                      i_q_req,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [vldm_pkg::CNT_W-1:0]          o_entry_count,
    output logic signed [vldm_pkg::VAL_W-1:0]   o_mean_value,
    output logic                                o_mean_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DIV,
        S_WAIT
    } t_state;

    t_state                                r_state;
    logic [vldm_pkg::VAL_W-1:0]            r_mem [vldm_pkg::CAPACITY];
    logic [vldm_pkg::VAL_W-1:0]            r_rdata;
    logic [vldm_pkg::IDX_W-1:0]            r_idx;
    logic [vldm_pkg::CNT_W-1:0]            r_count;
    logic signed [vldm_pkg::SUM_W-1:0]     r_sum;
    logic signed [vldm_pkg::VAL_W-1:0]     r_value;
    vldm_pkg::t_status                     r_status;
    logic                                  r_out_valid;
    vldm_pkg::t_status                     r_out_status;
    logic [vldm_pkg::CNT_W-1:0]            r_out_count;
    logic signed [vldm_pkg::VAL_W-1:0]     r_out_mean;
    logic                                  r_out_mvalid;

    logic                                  pop;
    logic                                  we;
    logic [vldm_pkg::IDX_W-1:0]            waddr;
    logic [vldm_pkg::VAL_W-1:0]            wdata;
    logic [vldm_pkg::IDX_W-1:0]            raddr;
    logic [vldm_pkg::CNT_W-1:0]            idx_p1;
    logic [vldm_pkg::CNT_W-1:0]            idx_p2;
    logic signed [vldm_pkg::SUM_W-1:0]     val_ext;
    logic signed [vldm_pkg::SUM_W-1:0]     q_val_ext;
    logic                                  sum_neg;
    logic [vldm_pkg::SUM_W-1:0]            sum_mag;
    logic                                  div_start;
    logic                                  div_done;
    logic [vldm_pkg::SUM_W-1:0]            div_q;
    logic [vldm_pkg::SUM_W-1:0]            mean_full;

    assign pop       = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign o_q_pop   = pop;
    assign idx_p1    = vldm_pkg::CNT_W'(r_idx) + vldm_pkg::CNT_W'(1);
    assign idx_p2    = vldm_pkg::CNT_W'(r_idx) + vldm_pkg::CNT_W'(2);
    assign val_ext   = vldm_pkg::SUM_W'(r_value);
    assign q_val_ext = vldm_pkg::SUM_W'(i_q_req.value);

    // sign and magnitude for the divider, sign restored after
    assign sum_neg   = r_sum[vldm_pkg::SUM_W-1];
    assign sum_mag   = sum_neg ? (-r_sum) : r_sum;
    assign div_start = (r_state == S_DIV) && (r_count != '0);
    assign mean_full = sum_neg ? (-div_q) : div_q;

    vldm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // store port control
    always_comb begin
        we    = 1'b0;
        waddr = r_count[vldm_pkg::IDX_W-1:0];
        wdata = i_q_req.value;
        raddr = idx_p1[vldm_pkg::IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (pop && (i_q_req.req_type == vldm_pkg::REQ_APPEND) &&
                    (r_count != vldm_pkg::CNT_W'(vldm_pkg::CAPACITY))) begin
                    we = 1'b1;
                end
            end
            S_SEARCH: begin
                raddr = idx_p1[vldm_pkg::IDX_W-1:0];
            end
            S_SHIFT: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = r_rdata;
                raddr = idx_p2[vldm_pkg::IDX_W-1:0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // value store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // sequencer, list state and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_value      <= '0;
            r_status     <= vldm_pkg::ST_DONE;
            r_out_status <= vldm_pkg::ST_DONE;
            r_out_count  <= '0;
            r_out_mean   <= '0;
            r_out_mvalid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_value <= i_q_req.value;
                        r_idx   <= '0;
                        if (i_q_req.req_type == vldm_pkg::REQ_APPEND) begin
                            r_state <= S_DIV;
                            if (r_count == vldm_pkg::CNT_W'(vldm_pkg::CAPACITY)) begin
                                r_status <= vldm_pkg::ST_FULL;
                            end else begin
                                r_status <= vldm_pkg::ST_DONE;
                                r_count  <= r_count + 1'b1;
                                r_sum    <= r_sum + q_val_ext;
                            end
                        end else if (r_count == '0) begin
                            r_status <= vldm_pkg::ST_EMPTY;
                            r_state  <= S_DIV;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // r_rdata holds the entry at r_idx
                    if (r_rdata == r_value) begin
                        if (idx_p1 == r_count) begin
                            r_status <= vldm_pkg::ST_DONE;
                            r_count  <= r_count - 1'b1;
                            r_sum    <= r_sum - val_ext;
                            r_state  <= S_DIV;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else if (idx_p1 == r_count) begin
                        r_status <= vldm_pkg::ST_NOT_FOUND;
                        r_state  <= S_DIV;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // entry r_idx+1 moves down to r_idx
                    if (idx_p2 == r_count) begin
                        r_status <= vldm_pkg::ST_DONE;
                        r_count  <= r_count - 1'b1;
                        r_sum    <= r_sum - val_ext;
                        r_state  <= S_DIV;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_count == '0) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        r_out_mean   <= '0;
                        r_out_mvalid <= 1'b0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        r_out_mean   <= mean_full[vldm_pkg::VAL_W-1:0];
                        r_out_mvalid <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;
    assign o_mean_value  = r_out_mean;
    assign o_mean_valid  = r_out_mvalid;

endmodule

@@ rtl/value_list_delete_and_mean.sv @@
// Sequence: an append offers its result beat after queue pop, divider load,
// 22 divider steps and the result register; a delete first searches the
// stored entries and shifts the later ones down. A request that leaves the
// list empty skips the divider. The list takes one request at a time; a
// two-entry queue in front takes beats meanwhile. Reset (sync, active low)
// empties all.
// ----------------------------------------------------------------------------
// value_list_delete_and_mean: ordered value list with delete and mean
// Appends Q8.8 values, deletes the first equal entry and closes the gap,
// and reports entry count and truncated mean on every request.
// ----------------------------------------------------------------------------
module value_list_delete_and_mean (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic signed [vldm_pkg::VAL_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [vldm_pkg::CNT_W-1:0]          o_entry_count,
    output logic signed [vldm_pkg::VAL_W-1:0]   o_mean_value,
    output logic                                o_mean_valid
);

    vldm_pkg::t_req    in_req;
    vldm_pkg::t_req    q_req;
    logic              q_valid;
    logic              q_pop;

    assign in_req.req_type = i_req_type;
    assign in_req.value    = i_value;

    vldm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req     (in_req),
        .o_stall   (o_stall),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    vldm_list u_list (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_req       (q_req),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_mean_value  (o_mean_value),
        .o_mean_valid  (o_mean_valid)
    );

endmodule

@@ rtl/vldm_checker.sv @@
// ----------------------------------------------------------------------------
// vldm_checker: port-level checks for the value list block
// Result beat consistency between status, count and mean flag.
// ----------------------------------------------------------------------------
module vldm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [1:0]                          o_status,
    input  logic [vldm_pkg::CNT_W-1:0]          o_entry_count,
    input  logic                                o_mean_valid
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result beat dropped while stalled");

    // mean flag follows a nonempty list
    a_mean_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mean_valid == (o_entry_count != '0)))
        else $error("mean_valid disagrees with entry_count");

    // full status only with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == vldm_pkg::ST_FULL)) |->
        (o_entry_count == vldm_pkg::CNT_W'(vldm_pkg::CAPACITY)))
        else $error("full status with list not full");

    // empty status only with an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == vldm_pkg::ST_EMPTY)) |->
        ((o_entry_count == '0) && !o_mean_valid))
        else $error("empty status with entries present");

    // count never exceeds the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= vldm_pkg::CNT_W'(vldm_pkg::CAPACITY)))
        else $error("entry_count beyond capacity");

endmodule

bind value_list_delete_and_mean vldm_checker u_vldm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_mean_valid  (o_mean_valid)
);

@@ test/value_list_delete_and_mean_checker.sv @@
// ----------------------------------------------------------------------------
// value_list_delete_and_mean_checker: list predictor and result comparison
// Watches both channels of the value list block. Every request beat is run
// through a local copy of the list, and every result beat is compared field
// by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module value_list_delete_and_mean_checker
    import vldm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_req_type,
    input  logic signed [VAL_W-1:0]  i_value,
    // result channel
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [1:0]               i_status,
    input  logic [CNT_W-1:0]         i_entry_count,
    input  logic signed [VAL_W-1:0]  i_mean_value,
    input  logic                     i_mean_valid,
    // to the testbench top
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status                 status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] mean;
        logic                    mean_ok;
    } t_list_result;

    // local copy of the list
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int                      list_len;
    longint                  list_sum;

    t_list_result outcome_queue [$];
    t_list_result want;
    int           fails;

    // apply one request to the local list and return the outcome it gives
    function automatic t_list_result list_outcome(logic kind, logic signed [VAL_W-1:0] v);
        t_list_result r;
        int           pos;
        int           k;
        longint       avg;
        r.status = ST_DONE;
        if (kind == REQ_APPEND) begin
            if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                list_vals[list_len] = v;
                list_len++;
                list_sum += longint'(v);
            end
        end else if (list_len == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // first match from the head
            pos = -1;
            for (k = 0; k < list_len; k++) begin
                if (pos < 0 && list_vals[k] == v) pos = k;
            end
            if (pos < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                // close the gap
                for (k = pos; k < list_len - 1; k++) list_vals[k] = list_vals[k + 1];
                list_len--;
                list_sum -= longint'(v);
            end
        end
        r.count = list_len[CNT_W-1:0];
        if (list_len != 0) begin
            avg       = list_sum / longint'(list_len);  // truncates toward zero
            r.mean    = avg[VAL_W-1:0];
            r.mean_ok = 1'b1;
        end else begin
            r.mean    = '0;
            r.mean_ok = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            list_sum = 0;
            fails    = 0;
            outcome_queue.delete();
        end else begin
            // result beat against the oldest outcome
            if (i_out_valid && !i_out_stall) begin
                if (outcome_queue.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fails++;
                end else begin
                    want = outcome_queue.pop_front();
                    if (t_status'(i_status) != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_entry_count != want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               i_entry_count);
                        fails++;
                    end
                    if (i_mean_value != want.mean) begin
                        $error("mean_value: expected %0d, got %0d", want.mean,
                               i_mean_value);
                        fails++;
                    end
                    if (i_mean_valid != want.mean_ok) begin
                        $error("mean_valid: expected %0d, got %0d", want.mean_ok,
                               i_mean_valid);
                        fails++;
                    end
                end
            end
            // request beat into the predictor
            if (i_in_valid && !i_in_stall) begin
                outcome_queue.push_back(list_outcome(i_req_type, i_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= outcome_queue.size();
    end

endmodule

@@ test/value_list_delete_and_mean_tb.sv @@
// ----------------------------------------------------------------------------
// value_list_delete_and_mean_tb: stimulus and verdict for the value list
// Drives directed corner requests, random mixes, repeated fill-to-capacity
// and drain-to-empty runs, and a long output hold, with random idling on
// both channels. The checker module predicts and compares every beat.
// ----------------------------------------------------------------------------
module value_list_delete_and_mean_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vldm_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES = 300;   // long output hold
    localparam int TAIL_CYCLES = 200;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_req_type;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_valid;
    logic                    i_stall;
    logic [1:0]              o_status;
    logic [CNT_W-1:0]        o_entry_count;
    logic signed [VAL_W-1:0] o_mean_value;
    logic                    o_mean_valid;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    logic [VAL_W-1:0] live_vals [$];
    logic [VAL_W-1:0] pool [6];
    int               n_sent;
    int               n_append;
    int               n_delete;
    int               n_fills;
    int               n_results;
    bit               send_burst;
    bit               recv_burst;
    bit               pressure_on;
    bit               hold_req;
    int unsigned      quiet_cycles;

    value_list_delete_and_mean dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_mean_value  (o_mean_value),
        .o_mean_valid  (o_mean_valid)
    );

    value_list_delete_and_mean_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_status      (o_status),
        .i_entry_count (o_entry_count),
        .i_mean_value  (o_mean_value),
        .i_mean_valid  (o_mean_valid),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles with no beat at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one request beat; returns at the accepting edge
    task automatic issue_request(logic kind, logic [VAL_W-1:0] v);
        int gap;
        int k;
        int pos;
        if (n_sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
        gap = (send_burst || pressure_on) ? 0 : $urandom_range(0, 13);
        // keep a view of the list to aim deletes at stored values
        if (kind == REQ_APPEND) begin
            if (live_vals.size() < CAPACITY) live_vals.push_back(v);
            n_append++;
        end else begin
            pos = -1;
            for (k = 0; k < live_vals.size(); k++) begin
                if (pos < 0 && live_vals[k] == v) pos = k;
            end
            if (pos >= 0) live_vals.delete(pos);
            n_delete++;
        end
        n_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_value    <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random appends and deletes over a small pool of recurring values
    task automatic random_mix(int n);
        int               j;
        logic             kind;
        logic [VAL_W-1:0] v;
        for (j = 0; j < 6; j++) pool[j] = VAL_W'($urandom);
        for (j = 0; j < n; j++) begin
            kind = ($urandom_range(0, 99) < 55) ? REQ_APPEND : REQ_DELETE;
            if (kind == REQ_DELETE && live_vals.size() > 0 && $urandom_range(0, 4) != 0)
                v = live_vals[$urandom_range(0, live_vals.size() - 1)];
            else if ($urandom_range(0, 1) == 0)
                v = pool[$urandom_range(0, 5)];
            else
                v = VAL_W'($urandom);
            issue_request(kind, v);
        end
    endtask

    // fill past capacity, then drain past empty
    // style 0: all most positive, 1: all most negative, else random
    task automatic fill_and_drain(int style);
        int               j;
        logic [VAL_W-1:0] v;
        for (j = 0; j < CAPACITY + 3; j++) begin
            case (style)
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                default: begin
                    case ($urandom_range(0, 7))
                        0: v = 16'h7FFF;
                        1: v = 16'h8000;
                        2: v = pool[$urandom_range(0, 5)];
                        default: v = VAL_W'($urandom);
                    endcase
                end
            endcase
            issue_request(REQ_APPEND, v);
        end
        while (live_vals.size() > 0) begin
            if ($urandom_range(0, 9) == 0)
                v = VAL_W'($urandom);
            else
                v = live_vals[$urandom_range(0, live_vals.size() - 1)];
            issue_request(REQ_DELETE, v);
        end
        issue_request(REQ_DELETE, VAL_W'($urandom));
        issue_request(REQ_DELETE, VAL_W'($urandom));
        n_fills++;
    endtask

    // result side: random stall before each beat, plus one long hold
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (n_results % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            n_results++;
        end
    end

    // stimulus and verdict
    initial begin
        int j;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = REQ_APPEND;
        i_value      = '0;
        i_stall      = 1'b0;
        quiet_cycles = 0;
        n_sent       = 0;
        n_append     = 0;
        n_delete     = 0;
        n_fills      = 0;
        n_results    = 0;
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        pressure_on  = 1'b0;
        hold_req     = 1'b0;
        for (j = 0; j < 6; j++) pool[j] = VAL_W'($urandom);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners: empty delete, extremes, absent value, duplicates,
        // negative means truncated toward zero, list emptied by a delete
        issue_request(REQ_DELETE, 16'h0000);
        issue_request(REQ_APPEND, 16'h7FFF);
        issue_request(REQ_APPEND, 16'h8000);
        issue_request(REQ_APPEND, 16'hFFFF);
        issue_request(REQ_DELETE, 16'h1234);
        issue_request(REQ_APPEND, 16'h0005);
        issue_request(REQ_APPEND, 16'h0005);
        issue_request(REQ_APPEND, 16'h0007);
        issue_request(REQ_DELETE, 16'h0005);
        issue_request(REQ_DELETE, 16'h0005);
        issue_request(REQ_DELETE, 16'h0005);
        issue_request(REQ_DELETE, 16'h7FFF);
        issue_request(REQ_DELETE, 16'h8000);
        issue_request(REQ_DELETE, 16'h0007);
        issue_request(REQ_DELETE, 16'hFFFF);
        issue_request(REQ_DELETE, 16'hFFFF);
        issue_request(REQ_APPEND, 16'hFFFD);
        issue_request(REQ_APPEND, 16'hFFFE);
        issue_request(REQ_APPEND, 16'h0000);
        issue_request(REQ_DELETE, 16'hFFFD);
        issue_request(REQ_DELETE, 16'hFFFE);
        issue_request(REQ_DELETE, 16'h0000);
        issue_request(REQ_APPEND, 16'h0100);
        issue_request(REQ_DELETE, 16'h0100);
        drain_results();

        random_mix(600);
        drain_results();

        // long output hold while requests keep coming back to back
        hold_req    = 1'b1;
        pressure_on = 1'b1;
        random_mix(24);
        pressure_on = 1'b0;
        drain_results();

        fill_and_drain(0);
        fill_and_drain(1);
        drain_results();
        for (j = 0; j < 4; j++) fill_and_drain(2);
        drain_results();

        random_mix(360);
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests (%0d appends, %0d deletes), %0d results checked,",
                 n_sent, n_append, n_delete, n_results);
        $display("including %0d fill-to-capacity and drain-to-empty runs and a long hold.",
                 n_fills);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
